@@ rtl/tcw_pkg.sv @@
// Shared types and constants of the text console writer.
package tcw_pkg;

	// Operation codes carried in the input tuser field
	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COPY,
		ST_FILL,
		ST_RESP
	} state_t;

	// Character codes
	localparam logic [7:0] NEWLINE_CODE = 8'd10;
	localparam logic [7:0] BLANK_CODE   = 8'd32;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic copy_step;
		logic fill_step;
		logic load_out;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic put_scroll;
		logic copy_last;
		logic fill_last;
		logic out_free;
	} dp_status_t;

endpackage

@@ rtl/tcw_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, holds when not reading
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/tcw_datapath.sv @@
// Datapath: cursor, screen store, sweep counter, fill attribute and result register.
module tcw_datapath #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tcw_pkg::ctrl_cmd_t     cmd,
	output tcw_pkg::dp_status_t    status,
	input  tcw_pkg::op_t           in_op,
	input  logic [7:0]             in_char,
	input  logic [7:0]             in_color,
	input  logic [10:0]            in_idx,
	input  logic                   cfg_valid,
	input  logic [7:0]             cfg_data,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic [31:0]            out_data
);
	import tcw_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;
	localparam int NCOPY = COLUMNS * (ROWS - 1);
	localparam int AW    = $clog2(CELLS);
	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLUMNS);

	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic [AW-1:0] addr_q;
	logic [AW-1:0] cnt_q;
	logic [7:0]    fill_attr_q;
	op_t           op_q;
	logic          rd_ok_q;
	logic          scrolled_q;
	logic          out_valid_q;
	logic [31:0]   out_data_q;

	logic          is_nl;
	logic          wrap;
	logic          row_adv;
	logic          put_scroll;
	logic [AW:0]   addr_inc;
	logic [AW:0]   addr_nl;
	logic          in_range;
	logic [AW+10:0] idx_ext;
	logic [AW:0]   copy_src;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [15:0]   ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [15:0]   ram_rdata;
	logic [15:0]   blank;
	logic          out_free;
	logic [15:0]   cell_out;
	logic [RW+4:0] row_wide;
	logic [CW+6:0] col_wide;

	// Cursor advance for a put
	always_comb begin
		is_nl      = (in_char == NEWLINE_CODE);
		wrap       = (col_q == CW'(COLUMNS - 1));
		row_adv    = is_nl || wrap;
		put_scroll = row_adv && (row_q == RW'(ROWS - 1));
		addr_inc   = {1'b0, addr_q} + (AW+1)'(1);
		addr_nl    = {1'b0, addr_q} - (AW+1)'(col_q) + (AW+1)'(COLUMNS);
	end

	// Read index check and address
	always_comb begin
		in_range = (32'(in_idx) < CELLS);
		idx_ext  = (AW+11)'(in_idx);
		copy_src = (AW+1)'(cnt_q) + (AW+1)'(COLUMNS);
		blank    = {fill_attr_q, BLANK_CODE};
	end

	// Steer the store ports
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = {in_color, in_char};
		ram_re    = 1'b0;
		ram_raddr = idx_ext[AW-1:0];
		priority if (cmd.accept) begin
			ram_we = (in_op == OP_PUT) && !is_nl;
			ram_re = (in_op == OP_READ) && in_range;
		end else if (cmd.copy_step) begin
			ram_we    = (cnt_q != '0);
			ram_waddr = cnt_q - AW'(1);
			ram_wdata = ram_rdata;
			ram_re    = (cnt_q != AW'(NCOPY));
			ram_raddr = copy_src[AW-1:0];
		end else if (cmd.fill_step) begin
			ram_we    = 1'b1;
			ram_waddr = cnt_q;
			ram_wdata = blank;
		end else begin
			// Idle: leave the store untouched
			ram_we = 1'b0;
			ram_re = 1'b0;
		end
	end

	tcw_ram #(
		.WIDTH(16),
		.DEPTH(CELLS)
	) u_store (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.re     (ram_re),
		.raddr  (ram_raddr),
		.rdata_q(ram_rdata)
	);

	// Hold the fill attribute
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_attr_q <= 8'd31;
		end else if (cfg_valid) begin
			fill_attr_q <= cfg_data;
		end
	end

	// Cursor and linear cursor address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			col_q  <= '0;
			addr_q <= '0;
		end else if (cmd.accept) begin
			if (in_op == OP_CLEAR) begin
				row_q  <= '0;
				col_q  <= '0;
				addr_q <= '0;
			end else if (in_op == OP_PUT) begin
				if (put_scroll) begin
					col_q  <= '0;
					addr_q <= AW'(NCOPY);
				end else if (row_adv) begin
					row_q  <= row_q + RW'(1);
					col_q  <= '0;
					addr_q <= is_nl ? addr_nl[AW-1:0] : addr_inc[AW-1:0];
				end else begin
					col_q  <= col_q + CW'(1);
					addr_q <= addr_inc[AW-1:0];
				end
			end
		end
	end

	// Latch what the result needs
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q       <= in_op;
			rd_ok_q    <= in_range;
			scrolled_q <= (in_op == OP_PUT) && put_scroll;
		end
	end

	// Sweep counter for scroll copy and blank fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.accept) begin
			cnt_q <= '0;
		end else if (cmd.copy_step) begin
			if (cnt_q != AW'(NCOPY)) begin
				cnt_q <= cnt_q + AW'(1);
			end
		end else if (cmd.fill_step) begin
			cnt_q <= cnt_q + AW'(1);
		end
	end

	// Result fields
	always_comb begin
		cell_out = ((op_q == OP_READ) && rd_ok_q) ? ram_rdata : 16'd0;
		row_wide = (RW+5)'(row_q);
		col_wide = (CW+7)'(col_q);
		out_free = !out_valid_q || out_ready;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_data_q <= {3'b000, scrolled_q, col_wide[6:0], row_wide[4:0], cell_out};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Status to the controller
	always_comb begin
		status.put_scroll = put_scroll;
		status.copy_last  = (cnt_q == AW'(NCOPY));
		status.fill_last  = (cnt_q == AW'(CELLS - 1));
		status.out_free   = out_free;
	end

endmodule

@@ rtl/tcw_ctrl.sv @@
// Controller: sequences accept, scroll copy, blank fill and result hand-off.
module tcw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  tcw_pkg::op_t        in_op,
	output logic                in_ready,
	input  tcw_pkg::dp_status_t status,
	output tcw_pkg::ctrl_cmd_t  cmd
);
	import tcw_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		cmd.accept    = 1'b0;
		cmd.copy_step = 1'b0;
		cmd.fill_step = 1'b0;
		cmd.load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid) begin
					if (in_op == OP_CLEAR) begin
						state_d = ST_FILL;
					end else if (in_op == OP_PUT && status.put_scroll) begin
						state_d = ST_COPY;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_COPY: begin
				cmd.copy_step = 1'b1;
				if (status.copy_last) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				cmd.fill_step = 1'b1;
				if (status.fill_last) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				cmd.load_out = status.out_free;
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ rtl/text_console_writer.sv @@
// Top level: text console writer with a cursor and a screen store of 16-bit cells.
// Put, read and no-op items go through ST_RESP into the result register; no new item is taken before it is loaded.
// A put that scrolls first copies rows 1 to ROWS-1 up by one row, then blanks the last row.
// A clear fills the whole store with blanks, one cell a cycle, before the result.
// The result register frees the next accept as soon as the result waits there.
// Reset clears cursor, controller and result valid, and sets fill_attr to 31; store is not cleared.
module text_console_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // char_code[7:0], color[15:8], cell_index[26:16]
	input  logic [1:0]  s_axis_tuser,  // op[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // cell_value[15:0], cursor_row[20:16],
	                                   // cursor_col[27:21], scrolled[28]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data       // fill_attr[7:0]
);
	import tcw_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;
	op_t        in_op;

	assign in_op     = op_t'(s_axis_tuser);
	assign cfg_ready = 1'b1;

	tcw_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_op   (in_op),
		.in_ready(s_axis_tready),
		.status  (status),
		.cmd     (cmd)
	);

	tcw_datapath #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.in_op    (in_op),
		.in_char  (s_axis_tdata[7:0]),
		.in_color (s_axis_tdata[15:8]),
		.in_idx   (s_axis_tdata[26:16]),
		.cfg_valid(cfg_valid),
		.cfg_data (cfg_data),
		.out_ready(m_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_data (m_axis_tdata)
	);

endmodule
